FILE: hw/rtl/elhc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elhc_pkg
// Shared types, codes and byte classes for the EHLO line syntax checker.
// ----------------------------------------------------------------------------
package elhc_pkg;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] FIELD_MAX  = 8'hFF;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_KEY   = 3'd1,
    PH_SEP   = 3'd2,
    PH_PARAM = 3'd3,
    PH_ERR   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ROLE_KEY   = 2'd0,
    ROLE_SPACE = 2'd1,
    ROLE_PARAM = 2'd2,
    ROLE_NONE  = 2'd3
  } role_t;

  typedef enum logic [2:0] {
    ST_CONT     = 3'd0,
    ST_ACCEPT   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADKEY   = 3'd3,
    ST_MISSING  = 3'd4,
    ST_BADPARAM = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       end_of_line;
  } item_t;

  typedef struct packed {
    role_t      char_role;
    logic [7:0] field_number;
    status_t    status;
    logic       line_done;
  } result_t;

  function automatic logic is_alnum(input logic [7:0] c);
    is_alnum = c inside {[8'd48:8'd57], [8'd65:8'd90], [8'd97:8'd122]};
  endfunction

  function automatic logic is_param_byte(input logic [7:0] c);
    is_param_byte = c inside {[8'd33:8'd126]};
  endfunction

endpackage

FILE: hw/rtl/elhc_in_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elhc_in_buf
// Input register: holds one incoming word until the parser takes it.
// ----------------------------------------------------------------------------
module elhc_in_buf (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  elhc_pkg::item_t in_item,
  output logic            buf_valid,
  input  logic            buf_take,
  output elhc_pkg::item_t buf_item
);
  import elhc_pkg::*;

  // accept when empty or when the held word leaves this cycle
  assign in_ready = !buf_valid || buf_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (in_ready) begin
      buf_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      buf_item <= in_item;
    end
  end

endmodule

FILE: hw/rtl/elhc_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elhc_parser
// Line state machine: classifies one word per step and tracks field count
// and the latched error.
// ----------------------------------------------------------------------------
module elhc_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step_en,
  input  elhc_pkg::item_t   item,
  output elhc_pkg::result_t result
);
  import elhc_pkg::*;

  phase_t     phase, phase_step, phase_next;
  logic [7:0] field_count, field_step, field_count_next;
  status_t    error_code, error_step, error_code_next;
  role_t      role;
  status_t    status;
  logic [7:0] field_bumped;

  assign field_bumped = (field_count == FIELD_MAX) ? field_count : field_count + 8'd1;

  // next state: effect of the byte, then close the line on end marker
  always_comb begin
    phase_step = phase;
    field_step = field_count;
    error_step = error_code;
    if (item.has_char) begin
      case (phase)
        PH_START: begin
          if (is_alnum(item.char_code)) begin
            phase_step = PH_KEY;
          end else begin
            phase_step = PH_ERR;
            error_step = ST_BADKEY;
          end
        end
        PH_KEY: begin
          if (is_alnum(item.char_code) || item.char_code == CHAR_DASH) begin
            phase_step = PH_KEY;
          end else if (item.char_code == CHAR_SPACE) begin
            phase_step = PH_SEP;
            field_step = field_bumped;
          end else begin
            phase_step = PH_ERR;
            error_step = ST_BADKEY;
          end
        end
        PH_SEP: begin
          if (item.char_code == CHAR_SPACE) begin
            phase_step = PH_ERR;
            error_step = ST_MISSING;
          end else if (is_param_byte(item.char_code)) begin
            phase_step = PH_PARAM;
          end else begin
            phase_step = PH_ERR;
            error_step = ST_BADPARAM;
          end
        end
        PH_PARAM: begin
          if (item.char_code == CHAR_SPACE) begin
            phase_step = PH_SEP;
            field_step = field_bumped;
          end else if (is_param_byte(item.char_code)) begin
            phase_step = PH_PARAM;
          end else begin
            phase_step = PH_ERR;
            error_step = ST_BADPARAM;
          end
        end
        default: begin
          phase_step = PH_ERR;
        end
      endcase
    end

    if (item.end_of_line) begin
      phase_next       = PH_START;
      field_count_next = 8'd0;
      error_code_next  = ST_CONT;
    end else begin
      phase_next       = phase_step;
      field_count_next = field_step;
      error_code_next  = error_step;
    end
  end

  // outputs: role of this byte and line status
  always_comb begin
    role = ROLE_NONE;
    if (item.has_char) begin
      case (phase_step)
        PH_KEY:   role = ROLE_KEY;
        PH_SEP:   role = ROLE_SPACE;
        PH_PARAM: role = ROLE_PARAM;
        default:  role = ROLE_NONE;
      endcase
    end

    if (phase_step == PH_ERR) begin
      status = error_step;
    end else if (item.end_of_line) begin
      case (phase_step)
        PH_START: status = ST_EMPTY;
        PH_SEP:   status = ST_MISSING;
        default:  status = ST_ACCEPT;
      endcase
    end else begin
      status = ST_CONT;
    end

    result.char_role    = role;
    result.field_number = field_step;
    result.status       = status;
    result.line_done    = item.end_of_line;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      field_count <= 8'd0;
      error_code  <= ST_CONT;
    end else if (step_en) begin
      phase       <= phase_next;
      field_count <= field_count_next;
      error_code  <= error_code_next;
    end
  end

`ifndef SYNTHESIS
  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    step_en && item.end_of_line |=>
      phase == PH_START && field_count == 8'd0 && error_code == ST_CONT)
    else $error("line state not cleared after end of line");

  a_err_latched: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ERR) == (error_code != ST_CONT))
    else $error("error phase and error code disagree");

  a_field_monotonic: assert property (@(posedge clk) disable iff (rst)
    step_en && !item.end_of_line |=> field_count >= $past(field_count))
    else $error("field count dropped inside a line");

  a_err_no_role: assert property (@(posedge clk) disable iff (rst)
    (result.status == ST_BADKEY || result.status == ST_MISSING ||
     result.status == ST_BADPARAM) && phase_step == PH_ERR |->
      result.char_role == ROLE_NONE)
    else $error("byte in error carries a role");
`endif

endmodule

FILE: hw/rtl/elhc_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elhc_out_reg
// Result register: holds one finished word until the consumer takes it.
// ----------------------------------------------------------------------------
module elhc_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  output logic              res_ready,
  input  elhc_pkg::result_t res_word,
  output logic              out_valid,
  input  logic              out_ready,
  output elhc_pkg::result_t out_word
);
  import elhc_pkg::*;

  // load when empty or when the held word is taken this cycle
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_word <= res_word;
    end
  end

endmodule

FILE: hw/rtl/ehlo_line_syntax_checker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehlo_line_syntax_checker_unit
// Byte-wise syntax checker for one SMTP EHLO reply line.
// ----------------------------------------------------------------------------
// Feed the line one word per cycle: a byte on char_code with has_char set,
// or a bare end marker with has_char clear; end_of_line flags the last word
// of the line. Every input word yields exactly one result word with the
// byte's role, its field number (0 keyword, k for the k-th parameter,
// saturating at 255), a status and line_done. The unit sustains one word per
// clock while out_ready stays high; each word passes through the input
// register and then the result register, and the parser's phase, field count
// and error registers update once per word as it moves between them. The
// first error is latched and repeated until end of line, and end of line
// returns all line state to its reset values. A missing parameter after a
// space shows at the next byte or end marker, or at a space ending the line.
// ----------------------------------------------------------------------------
module ehlo_line_syntax_checker_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic       has_char,
  input  logic       end_of_line,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] char_role,
  output logic [7:0] field_number,
  output logic [2:0] status,
  output logic       line_done
);
  import elhc_pkg::*;

  item_t   in_item;
  item_t   buf_item;
  logic    buf_valid;
  logic    res_ready;
  logic    step_en;
  result_t res_word;
  result_t out_word;

  assign in_item.char_code   = char_code;
  assign in_item.has_char    = has_char;
  assign in_item.end_of_line = end_of_line;

  // advance the parser whenever a held word can move into the result register
  assign step_en = buf_valid && res_ready;

  elhc_in_buf u_in_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .buf_valid (buf_valid),
    .buf_take  (step_en),
    .buf_item  (buf_item)
  );

  elhc_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .item    (buf_item),
    .result  (res_word)
  );

  elhc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (buf_valid),
    .res_ready (res_ready),
    .res_word  (res_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  // drop the enum types at the pins
  assign char_role    = 2'(out_word.char_role);
  assign field_number = out_word.field_number;
  assign status       = 3'(out_word.status);
  assign line_done    = out_word.line_done;

endmodule
